>>> design/srt_pkg.sv
// Shared constants and pipeline types for the radix-4 SRT divider.
// No dependencies; imported by every design module and the checker.
package srt_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int DIGIT_STEPS   = 28;
    localparam int FULL_STEPS    = 28;
    localparam int MANT_BITS     = 57;
    localparam int EXP_BITS      = 5;

    // normalised operands are scaled by 2^-OPERAND_WIDTH
    localparam int MAG_W  = OPERAND_WIDTH + 1;
    localparam int EXT_W  = OPERAND_WIDTH + 2;
    localparam int REM_W  = OPERAND_WIDTH + 4;
    localparam int CMP_W  = OPERAND_WIDTH + 5;
    localparam int LOG_W  = $clog2(OPERAND_WIDTH + 1);
    localparam int MANT_SHIFT = 2 * (FULL_STEPS - DIGIT_STEPS);

    typedef struct packed {
        logic             dbz;
        logic             nneg;
        logic [MAG_W-1:0] nmag;
        logic [MAG_W-1:0] dmag;
    } prep_t;

    typedef struct packed {
        logic                        dbz;
        logic signed [REM_W-1:0]     rem;
        logic [MAG_W-1:0]            dv;
        logic signed [MANT_BITS-1:0] acc;
        logic signed [EXP_BITS-1:0]  expo;
    } work_t;

endpackage

>>> design/srt_radix4_divider.sv
// Top level of the radix-4 SRT divider: input skid register, front end,
// digit pipeline and output register. Depends on srt_pkg, srt_prep, srt_digit_stage.
//
// Usage:
//  - Input channel s_valid/s_ready carries s_dividend and s_divisor (signed).
//  - Result channel m_valid/m_ready carries m_quotient_mantissa (scale 2^-54),
//    m_scale_exponent and m_divide_by_zero; quotient = mantissa * 2^-54 * 2^exp.
//  - A zero divisor gives divide_by_zero set and zero mantissa and exponent.
//  - Pipeline: DIGIT_STEPS + 3 register stages: two front-end stages, one per digit
//    step, and the output register.
//  - Throughput: one transaction per cycle while the output is not stalled; each digit
//    step has its own stage, so the digit pipeline depth sets latency, not rate.
//  - Stall: while m_valid is high and m_ready low the whole pipeline holds;
//    one incoming transaction is caught in the skid register and s_ready drops
//    until it drains. s_ready never depends combinationally on m_ready.
//  - Reset (aresetn low, synchronous): all valid bits clear, s_ready high,
//    m_valid low. No clearing pass.
module srt_radix4_divider (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [srt_pkg::OPERAND_WIDTH-1:0] s_dividend,
    input  logic signed [srt_pkg::OPERAND_WIDTH-1:0] s_divisor,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [srt_pkg::MANT_BITS-1:0]  m_quotient_mantissa,
    output logic signed [srt_pkg::EXP_BITS-1:0]   m_scale_exponent,
    output logic                                  m_divide_by_zero
);
    import srt_pkg::*;

    logic                            skid_valid_reg, skid_valid_next;
    logic signed [OPERAND_WIDTH-1:0] skid_dividend_reg, skid_divisor_reg;
    logic                            adv;
    logic                            feed_valid;
    logic signed [OPERAND_WIDTH-1:0] feed_dividend, feed_divisor;

    logic  chain_valid [0:DIGIT_STEPS];
    work_t chain_work  [0:DIGIT_STEPS];

    logic                        out_valid_reg;
    logic signed [MANT_BITS-1:0] out_mant_reg, out_mant_next;
    logic signed [EXP_BITS-1:0]  out_exp_reg, out_exp_next;
    logic                        out_dbz_reg;

    assign adv           = !out_valid_reg || m_ready;
    assign s_ready       = !skid_valid_reg;
    assign feed_valid    = skid_valid_reg || s_valid;
    assign feed_dividend = skid_valid_reg ? skid_dividend_reg : s_dividend;
    assign feed_divisor  = skid_valid_reg ? skid_divisor_reg : s_divisor;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (adv) begin
            skid_valid_next = 1'b0;
        end else if (s_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_valid && !skid_valid_reg) begin
            skid_dividend_reg <= s_dividend;
            skid_divisor_reg  <= s_divisor;
        end
    end

    srt_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (feed_valid),
        .dividend  (feed_dividend),
        .divisor   (feed_divisor),
        .out_valid (chain_valid[0]),
        .out_work  (chain_work[0])
    );

    for (genvar i = 0; i < DIGIT_STEPS; i++) begin : g_step
        srt_digit_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    always_comb begin
        if (chain_work[DIGIT_STEPS].dbz) begin
            out_mant_next = '0;
            out_exp_next  = '0;
        end else begin
            out_mant_next = chain_work[DIGIT_STEPS].acc <<< MANT_SHIFT;
            out_exp_next  = chain_work[DIGIT_STEPS].expo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= chain_valid[DIGIT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_mant_reg <= out_mant_next;
            out_exp_reg  <= out_exp_next;
            out_dbz_reg  <= chain_work[DIGIT_STEPS].dbz;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_quotient_mantissa = out_mant_reg;
    assign m_scale_exponent    = out_exp_reg;
    assign m_divide_by_zero    = out_dbz_reg;

endmodule

>>> design/srt_prep.sv
// Front end of the divider: sign handling, then normalisation of both operands.
// Two register stages. Depends on srt_pkg.
module srt_prep (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic signed [srt_pkg::OPERAND_WIDTH-1:0] dividend,
    input  logic signed [srt_pkg::OPERAND_WIDTH-1:0] divisor,
    output logic                                  out_valid,
    output srt_pkg::work_t                        out_work
);
    import srt_pkg::*;

    prep_t prep_reg, prep_next;
    logic  prep_valid_reg;
    work_t work_reg, work_next;
    logic  work_valid_reg;

    function automatic logic [LOG_W-1:0] msb_index(input logic [MAG_W-1:0] mag);
        logic [LOG_W-1:0] e;
        e = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (mag[k]) begin
                e = LOG_W'(k);
            end
        end
        return e;
    endfunction

    logic signed [EXT_W-1:0] n_x, d_x, n_abs;
    logic [LOG_W-1:0]        e1, e2;
    logic [MAG_W-1:0]        n_sh, d_sh;
    logic signed [LOG_W:0]   e_diff;

    always_comb begin
        n_x = EXT_W'(dividend);
        d_x = EXT_W'(divisor);
        if (divisor[OPERAND_WIDTH-1]) begin
            n_x = -n_x;
            d_x = -d_x;
        end
        n_abs = n_x[EXT_W-1] ? -n_x : n_x;
        prep_next.dbz  = (divisor == '0);
        prep_next.nneg = n_x[EXT_W-1];
        prep_next.nmag = n_abs[MAG_W-1:0];
        prep_next.dmag = d_x[MAG_W-1:0];
    end

    always_comb begin
        e1     = msb_index(prep_reg.nmag);
        e2     = msb_index(prep_reg.dmag);
        n_sh   = prep_reg.nmag << (LOG_W'(OPERAND_WIDTH) - e1);
        d_sh   = prep_reg.dmag << (LOG_W'(OPERAND_WIDTH) - e2);
        e_diff = signed'({1'b0, e1}) - signed'({1'b0, e2});
        work_next.dbz  = prep_reg.dbz;
        work_next.rem  = prep_reg.nneg ? -signed'(REM_W'(n_sh)) : signed'(REM_W'(n_sh));
        work_next.dv   = d_sh;
        work_next.acc  = '0;
        work_next.expo = EXP_BITS'(e_diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
            work_valid_reg <= 1'b0;
        end else if (adv) begin
            prep_valid_reg <= in_valid;
            work_valid_reg <= prep_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prep_reg <= prep_next;
            work_reg <= work_next;
        end
    end

    assign out_valid = work_valid_reg;
    assign out_work  = work_reg;

endmodule

>>> design/srt_digit_stage.sv
// One radix-4 SRT step: digit select in -2..2, remainder update, digit accumulate.
// One register stage. Depends on srt_pkg.
module srt_digit_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  srt_pkg::work_t in_work,
    output logic           out_valid,
    output srt_pkg::work_t out_work
);
    import srt_pkg::*;

    work_t work_reg, work_next;
    logic  valid_reg;

    logic                    neg;
    logic [1:0]              mag;
    logic signed [2:0]       digit;
    logic signed [CMP_W-1:0] rem_x, dv_x, dv3, a2, qdv, diff, diff4;

    always_comb begin
        rem_x = CMP_W'(in_work.rem);
        dv_x  = signed'(CMP_W'(in_work.dv));
        neg   = in_work.rem[REM_W-1];
        a2    = neg ? -(rem_x <<< 1) : (rem_x <<< 1);
        dv3   = dv_x + (dv_x <<< 1);
        if (a2 >= dv3) begin
            mag = 2'd2;
        end else if (a2 >= dv_x) begin
            mag = 2'd1;
        end else begin
            mag = 2'd0;
        end
        qdv   = (mag == 2'd2) ? (dv_x <<< 1) : ((mag == 2'd1) ? dv_x : '0);
        diff  = neg ? (rem_x + qdv) : (rem_x - qdv);
        diff4 = diff <<< 2;
        digit = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        work_next.dbz  = in_work.dbz;
        work_next.rem  = diff4[REM_W-1:0];
        work_next.dv   = in_work.dv;
        work_next.acc  = (in_work.acc <<< 2) + MANT_BITS'(digit);
        work_next.expo = in_work.expo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

>>> design/srt_checker.sv
// Port-level assertions for the radix-4 SRT divider, bound to the top level.
// Depends on srt_pkg and srt_radix4_divider.
module srt_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic signed [srt_pkg::OPERAND_WIDTH-1:0] s_dividend,
    input logic signed [srt_pkg::OPERAND_WIDTH-1:0] s_divisor,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [srt_pkg::MANT_BITS-1:0]  m_quotient_mantissa,
    input logic signed [srt_pkg::EXP_BITS-1:0]   m_scale_exponent,
    input logic                                  m_divide_by_zero
);
    import srt_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient_mantissa)
            && $stable(m_scale_exponent) && $stable(m_divide_by_zero))
        else $error("stalled result changed");

    // zero divisor clears mantissa and exponent
    a_dbz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_quotient_mantissa == '0 && m_scale_exponent == '0)
        else $error("divide-by-zero result not cleared");

    // s_ready only drops after an output stall
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready dropped without output stall");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind srt_radix4_divider srt_checker u_chk (.*);

>>> tb/testbench.sv
// Self-checking testbench for srt_radix4_divider: directed and random operand pairs,
// random idling on both channels, results checked against tabled values or a local quotient predictor.
// Depends on srt_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;
    import srt_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = DIGIT_STEPS + 12;
    localparam logic signed [MANT_BITS-1:0] UNIT_MANT = 57'sh40_0000_0000_0000;

    typedef struct packed {
        logic signed [MANT_BITS-1:0] mant;
        logic signed [EXP_BITS-1:0]  expo;
        logic                        dbz;
    } quotient_t;

    typedef struct packed {
        logic signed [OPERAND_WIDTH-1:0] num;
        logic signed [OPERAND_WIDTH-1:0] den;
        logic                            typed;
        quotient_t                       res;
    } stim_row_t;

    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{16'sd0,      16'sd0,      1'b1, '{57'sd0,    5'sd0,   1'b1}},
        '{16'sd32767,  16'sd0,      1'b1, '{57'sd0,    5'sd0,   1'b1}},
        '{-16'sd32768, 16'sd0,      1'b1, '{57'sd0,    5'sd0,   1'b1}},
        '{16'sd0,      16'sd1,      1'b1, '{57'sd0,    5'sd0,   1'b0}},
        '{16'sd0,      16'sd32767,  1'b1, '{57'sd0,    -5'sd14, 1'b0}},
        '{16'sd0,      -16'sd32768, 1'b1, '{57'sd0,    -5'sd15, 1'b0}},
        '{16'sd1,      16'sd1,      1'b1, '{UNIT_MANT, 5'sd0,   1'b0}},
        '{-16'sd1,     -16'sd1,     1'b1, '{UNIT_MANT, 5'sd0,   1'b0}},
        '{-16'sd32768, -16'sd32768, 1'b1, '{UNIT_MANT, 5'sd0,   1'b0}},
        '{-16'sd32768, 16'sd1,      1'b1, '{-UNIT_MANT, 5'sd15, 1'b0}},
        '{16'sd1,      -16'sd32768, 1'b1, '{-UNIT_MANT, -5'sd15, 1'b0}},
        '{16'sd32767,  16'sd1,      1'b0, '0},
        '{16'sd32767,  -16'sd1,     1'b0, '0},
        '{-16'sd32768, 16'sd32767,  1'b0, '0},
        '{16'sd32767,  -16'sd32768, 1'b0, '0},
        '{16'sd3,      16'sd2,      1'b0, '0},
        '{-16'sd3,     16'sd2,      1'b0, '0},
        '{16'sd2,      16'sd3,      1'b0, '0},
        '{16'sd1,      16'sd3,      1'b0, '0},
        '{-16'sd1,     16'sd3,      1'b0, '0},
        '{16'sd5,      16'sd7,      1'b0, '0},
        '{16'sd12345,  -16'sd321,   1'b0, '0},
        '{-16'sd7,     16'sd5,      1'b0, '0},
        '{16'sd21845,  16'sd3,      1'b0, '0},
        '{16'sd1,      16'sd32767,  1'b0, '0},
        '{-16'sd32767, 16'sd2,      1'b0, '0}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [OPERAND_WIDTH-1:0] s_dividend = '0;
    logic signed [OPERAND_WIDTH-1:0] s_divisor = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [MANT_BITS-1:0] m_quotient_mantissa;
    logic signed [EXP_BITS-1:0]  m_scale_exponent;
    logic                        m_divide_by_zero;

    stim_row_t pending_quotients [$];
    int        errors = 0;
    bit        calm_send = 1'b0;
    bit        calm_recv = 1'b0;

    srt_radix4_divider i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_dividend          (s_dividend),
        .s_divisor           (s_divisor),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_quotient_mantissa (m_quotient_mantissa),
        .m_scale_exponent    (m_scale_exponent),
        .m_divide_by_zero    (m_divide_by_zero)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int mag_halvings(input longint mag);
        int e;
        e = 0;
        while (e < OPERAND_WIDTH && mag >= (longint'(2) << e))
            e++;
        return e;
    endfunction

    function automatic quotient_t srt_quotient(input logic signed [OPERAND_WIDTH-1:0] num,
                                               input logic signed [OPERAND_WIDTH-1:0] den);
        longint n, d, nmag, r, dv, acc, q, a2;
        int e1, e2;
        quotient_t res;
        res = '0;
        n = longint'(num);
        d = longint'(den);
        if (d == 0) begin
            res.dbz = 1'b1;
            return res;
        end
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        nmag = (n < 0) ? -n : n;
        e1 = mag_halvings(nmag);
        e2 = mag_halvings(d);
        r = nmag << (OPERAND_WIDTH - e1);
        if (n < 0)
            r = -r;
        dv = d << (OPERAND_WIDTH - e2);
        acc = 0;
        for (int i = 0; i < DIGIT_STEPS && i < FULL_STEPS; i++) begin
            a2 = (r < 0) ? -2 * r : 2 * r;
            q = (a2 >= 3 * dv) ? 2 : (a2 >= dv) ? 1 : 0;
            if (r < 0)
                q = -q;
            acc = acc * 4 + q;
            r = 4 * (r - q * dv);
        end
        res.mant = MANT_BITS'(acc << (2 * (FULL_STEPS - DIGIT_STEPS)));
        res.expo = EXP_BITS'(e1 - e2);
        return res;
    endfunction

    // one transaction on the input channel; the expectation is queued on acceptance
    task automatic send_operands(input stim_row_t row);
        int gap;
        if (($urandom & 63) == 0)
            calm_send = !calm_send;
        gap = calm_send ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_dividend <= row.num;
        s_divisor <= row.den;
        do @(posedge aclk); while (!s_ready);
        if (!row.typed)
            row.res = srt_quotient(row.num, row.den);
        pending_quotients.push_back(row);
    endtask

    task automatic wait_all_quotients;
        s_valid <= 1'b0;
        while (pending_quotients.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic stim_row_t random_operands;
        stim_row_t row;
        row = '0;
        case ($urandom_range(0, 9))
            0: begin
                row.num = OPERAND_WIDTH'($urandom);
                row.den = '0;
            end
            1: begin
                row.num = OPERAND_WIDTH'($signed($urandom_range(0, 16)) - 8);
                row.den = OPERAND_WIDTH'($signed($urandom_range(0, 16)) - 8);
            end
            2: begin
                row.num = ($urandom & 1) ? 16'sh7fff : 16'sh8000;
                row.den = ($urandom & 1) ? OPERAND_WIDTH'($urandom) :
                          (($urandom & 1) ? 16'sh8000 : 16'sh0001);
            end
            default: begin
                row.num = OPERAND_WIDTH'($urandom);
                row.den = OPERAND_WIDTH'($urandom);
            end
        endcase
        return row;
    endfunction

    initial begin
        stim_row_t exp_row;
        quotient_t got;
        int gap;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (($urandom & 63) == 0)
                calm_recv = !calm_recv;
            gap = calm_recv ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = '{m_quotient_mantissa, m_scale_exponent, m_divide_by_zero};
            if (pending_quotients.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: mant=%0d exp=%0d dbz=%0b",
                             got.mant, got.expo, got.dbz);
            end else begin
                exp_row = pending_quotients.pop_front();
                if (got.mant !== exp_row.res.mant || got.expo !== exp_row.res.expo ||
                    got.dbz !== exp_row.res.dbz) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch %0d / %0d: exp mant=%0d exp=%0d dbz=%0b, ",
                                 exp_row.num, exp_row.den, exp_row.res.mant,
                                 exp_row.res.expo, exp_row.res.dbz,
                                 "got mant=%0d exp=%0d dbz=%0b",
                                 got.mant, got.expo, got.dbz);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (DIRECTED_ROWS[k])
            send_operands(DIRECTED_ROWS[k]);
        wait_all_quotients();
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2)
                wait_all_quotients();
            send_operands(random_operands());
        end
        wait_all_quotients();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
